// ===== hw/rtl/pnet_pkg.sv =====
// Shared types and constants of the Petri net event tracker.
// Used by pnet_cfg, pnet_step and petri_net_event_tracker; no dependencies.
package pnet_pkg;

    localparam int SLOTS      = 8;
    localparam int MASK_BITS  = 16;
    localparam int CODE_W     = 8;
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;
    localparam int CTRL_W     = 22;
    localparam int GOAL_W     = 4;

    // Register indexes (paddr[5:3])
    typedef enum logic [2:0] {
        REG_INPUTS_LO  = 3'd0,
        REG_INPUTS_HI  = 3'd1,
        REG_OUTPUTS_LO = 3'd2,
        REG_OUTPUTS_HI = 3'd3,
        REG_EVT_TYPES  = 3'd4,
        REG_SRC_ROLES  = 3'd5,
        REG_TGT_ROLES  = 3'd6,
        REG_NET_CTRL   = 3'd7
    } t_reg_idx;

    // net_control bit positions
    localparam int CTRL_GOAL_LSB = 16;
    localparam int CTRL_GOAL_EN  = 20;
    localparam int CTRL_LOADED   = 21;

    typedef struct packed {
        logic              kind;
        logic [CODE_W-1:0] event_type;
        logic [CODE_W-1:0] source_role;
        logic [CODE_W-1:0] target_role;
    } t_event_word;

    typedef struct packed {
        logic [MASK_BITS-1:0] marking;
        logic [SLOTS-1:0]     fired_transitions;
        logic                 goal_reached;
    } t_result_word;

    // Decoded net configuration handed from the register file to the datapath
    typedef struct packed {
        logic [SLOTS-1:0][MASK_BITS-1:0] in_mask;
        logic [SLOTS-1:0][MASK_BITS-1:0] out_mask;
        logic [SLOTS-1:0][CODE_W-1:0]    ev_type;
        logic [SLOTS-1:0][CODE_W-1:0]    src_role;
        logic [SLOTS-1:0][CODE_W-1:0]    tgt_role;
        logic [MASK_BITS-1:0]            init_marks;
        logic [GOAL_W-1:0]               goal_place;
        logic                            goal_en;
        logic                            loaded;
    } t_net_cfg;

endpackage

// ===== hw/rtl/pnet_cfg.sv =====
// APB register file of the Petri net event tracker.
// Depends on pnet_pkg; presents the net configuration as one struct.
module pnet_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pnet_pkg::ADDR_W-1:0] paddr,
    input  logic [pnet_pkg::DATA_W-1:0] pwdata,
    output logic [pnet_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output pnet_pkg::t_net_cfg          o_cfg
);
    import pnet_pkg::*;

    logic [DATA_W-1:0] r_inputs_lo, r_inputs_hi, r_outputs_lo, r_outputs_hi;
    logic [DATA_W-1:0] r_evt_types, r_src_roles, r_tgt_roles;
    logic [CTRL_W-1:0] r_net_ctrl;
    logic              wr_en;
    t_reg_idx          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inputs_lo  <= '0;
            r_inputs_hi  <= '0;
            r_outputs_lo <= '0;
            r_outputs_hi <= '0;
            r_evt_types  <= '0;
            r_src_roles  <= '0;
            r_tgt_roles  <= '0;
            r_net_ctrl   <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_INPUTS_LO:  r_inputs_lo  <= pwdata;
                REG_INPUTS_HI:  r_inputs_hi  <= pwdata;
                REG_OUTPUTS_LO: r_outputs_lo <= pwdata;
                REG_OUTPUTS_HI: r_outputs_hi <= pwdata;
                REG_EVT_TYPES:  r_evt_types  <= pwdata;
                REG_SRC_ROLES:  r_src_roles  <= pwdata;
                REG_TGT_ROLES:  r_tgt_roles  <= pwdata;
                REG_NET_CTRL:   r_net_ctrl   <= pwdata[CTRL_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_INPUTS_LO:  prdata = r_inputs_lo;
            REG_INPUTS_HI:  prdata = r_inputs_hi;
            REG_OUTPUTS_LO: prdata = r_outputs_lo;
            REG_OUTPUTS_HI: prdata = r_outputs_hi;
            REG_EVT_TYPES:  prdata = r_evt_types;
            REG_SRC_ROLES:  prdata = r_src_roles;
            REG_TGT_ROLES:  prdata = r_tgt_roles;
            REG_NET_CTRL:   prdata = {{(DATA_W-CTRL_W){1'b0}}, r_net_ctrl};
            default:        prdata = '0;
        endcase
    end

    // Four 16-bit masks per 64-bit word, transition 0 in the low bits
    always_comb begin
        o_cfg.in_mask  = {r_inputs_hi, r_inputs_lo};
        o_cfg.out_mask = {r_outputs_hi, r_outputs_lo};
        o_cfg.ev_type  = r_evt_types;
        o_cfg.src_role = r_src_roles;
        o_cfg.tgt_role = r_tgt_roles;
        o_cfg.init_marks = r_net_ctrl[MASK_BITS-1:0];
        o_cfg.goal_place = r_net_ctrl[CTRL_GOAL_LSB +: GOAL_W];
        o_cfg.goal_en    = r_net_ctrl[CTRL_GOAL_EN];
        o_cfg.loaded     = r_net_ctrl[CTRL_LOADED];
    end

endmodule

// ===== hw/rtl/pnet_step.sv =====
// One transition of the firing chain: match, test inputs, update marking.
// Depends on pnet_pkg; instantiated once per transition slot.
module pnet_step (
    input  logic                           i_enable,
    input  logic [pnet_pkg::MASK_BITS-1:0] i_marks,
    input  logic [pnet_pkg::MASK_BITS-1:0] i_in_mask,
    input  logic [pnet_pkg::MASK_BITS-1:0] i_out_mask,
    input  logic [pnet_pkg::CODE_W-1:0]    i_tr_type,
    input  logic [pnet_pkg::CODE_W-1:0]    i_tr_src,
    input  logic [pnet_pkg::CODE_W-1:0]    i_tr_tgt,
    input  logic [pnet_pkg::CODE_W-1:0]    i_ev_type,
    input  logic [pnet_pkg::CODE_W-1:0]    i_ev_src,
    input  logic [pnet_pkg::CODE_W-1:0]    i_ev_tgt,
    output logic [pnet_pkg::MASK_BITS-1:0] o_marks,
    output logic                           o_fired
);
    import pnet_pkg::*;

    logic type_ok, src_ok, tgt_ok, places_ok;

    assign type_ok   = (i_tr_type != '0) && (i_tr_type == i_ev_type);
    // A zero code on either side skips the role check
    assign src_ok    = (i_tr_src == '0) || (i_ev_src == '0) || (i_tr_src == i_ev_src);
    assign tgt_ok    = (i_tr_tgt == '0) || (i_ev_tgt == '0) || (i_tr_tgt == i_ev_tgt);
    assign places_ok = (i_marks & i_in_mask) == i_in_mask;
    assign o_fired   = i_enable & type_ok & src_ok & tgt_ok & places_ok;
    assign o_marks   = o_fired ? ((i_marks & ~i_in_mask) | i_out_mask) : i_marks;

endmodule

// ===== hw/rtl/petri_net_event_tracker.sv =====
// Top level of the one-safe Petri net event tracker.
// Depends on pnet_pkg, pnet_cfg and pnet_step.
//
// The block holds a one-safe marking of up to 16 places and runs each event
// word through up to eight configured transitions in slot order; each slot
// that fires clears its input places and sets its output places, and later
// slots see the updated marking. A restart word loads the initial marking
// from net_control. Every input word yields exactly one result word carrying
// the marking, the mask of fired transitions and the goal flag. Words pass
// the input register, then the result register; the block takes one word per
// clock unless stalled: the eight-slot chain is a single combinational
// pass from the input and marking registers to the result register.
// Configuration is through a 64-bit APB port, register i at byte address 8*i;
// write it only while no words are in flight.
module petri_net_event_tracker #(
    parameter int PLACES      = 16,
    parameter int TRANSITIONS = 8,
    parameter int CODE_BITS   = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // event channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  pnet_pkg::t_event_word       i_event,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output pnet_pkg::t_result_word      o_result,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pnet_pkg::ADDR_W-1:0] paddr,
    input  logic [pnet_pkg::DATA_W-1:0] pwdata,
    output logic [pnet_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import pnet_pkg::*;

    // Places that exist, code bits that count, slots that are visited
    localparam logic [MASK_BITS-1:0] PlaceMask =
        (PLACES >= MASK_BITS) ? {MASK_BITS{1'b1}} : MASK_BITS'((64'd1 << PLACES) - 64'd1);
    localparam logic [CODE_W-1:0] CodeMask =
        (CODE_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((32'd1 << CODE_BITS) - 32'd1);
    localparam int TxCount = (TRANSITIONS < SLOTS) ? TRANSITIONS : SLOTS;

    t_net_cfg cfg;

    pnet_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // ---------------- input register ----------------
    logic         r_in_valid;
    t_event_word  r_in;
    logic         r_out_valid;
    t_result_word r_out;
    logic [MASK_BITS-1:0] r_marks;

    logic advance;   // input register hands its word to the result register
    logic take_in;

    // Result register is free when empty or being drained this cycle
    assign advance = r_in_valid & (~r_out_valid | ~i_stall);
    assign o_stall = r_in_valid & ~advance;
    assign take_in = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in <= i_event;
        end
    end

    // ---------------- firing chain ----------------
    logic [CODE_W-1:0] ev_type, ev_src, ev_tgt;
    logic              run_net;
    logic [SLOTS:0][MASK_BITS-1:0] chain;
    logic [SLOTS-1:0]  fired;
    logic [MASK_BITS-1:0] n_marks;
    logic              goal_in_range;
    logic              n_goal;

    assign ev_type = r_in.event_type & CodeMask;
    assign ev_src  = r_in.source_role & CodeMask;
    assign ev_tgt  = r_in.target_role & CodeMask;
    // Skip the net for restart words, unloaded nets and empty event types
    assign run_net = ~r_in.kind & cfg.loaded & (ev_type != '0);
    assign chain[0] = r_marks;

    for (genvar t = 0; t < SLOTS; t++) begin : g_slot
        pnet_step u_step (
            .i_enable   (run_net & (t < TxCount)),
            .i_marks    (chain[t]),
            .i_in_mask  (cfg.in_mask[t]),
            // drop output bits naming places that do not exist
            .i_out_mask (cfg.out_mask[t] & PlaceMask),
            .i_tr_type  (cfg.ev_type[t] & CodeMask),
            .i_tr_src   (cfg.src_role[t] & CodeMask),
            .i_tr_tgt   (cfg.tgt_role[t] & CodeMask),
            .i_ev_type  (ev_type),
            .i_ev_src   (ev_src),
            .i_ev_tgt   (ev_tgt),
            .o_marks    (chain[t+1]),
            .o_fired    (fired[t])
        );
    end

    assign n_marks = r_in.kind ? (cfg.init_marks & PlaceMask) : chain[SLOTS];

    // Goal place beyond the last existing place is never reached
    assign goal_in_range = (32'(cfg.goal_place) < PLACES);
    assign n_goal = cfg.loaded & cfg.goal_en & goal_in_range & n_marks[cfg.goal_place];

    // ---------------- marking and result registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
        end else if (advance) begin
            r_marks <= n_marks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (~i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.marking           <= n_marks;
            r_out.fired_transitions <= r_in.kind ? '0 : fired;
            r_out.goal_reached      <= n_goal;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== test/pnet_firing_check.sv =====
`timescale 1ns / 100ps
// Result checker for the Petri net event tracker: tracks APB writes, predicts
// each result word from every accepted event word and compares. Uses pnet_pkg.
module pnet_firing_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_evt_valid,
    input  logic                          i_evt_stall,
    input  pnet_pkg::t_event_word         i_evt_word,
    input  logic                          i_res_valid,
    input  logic                          i_res_stall,
    input  pnet_pkg::t_result_word        i_res_word,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [pnet_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [pnet_pkg::DATA_W-1:0]   i_pwdata,
    output int                            o_pending,
    output int                            o_checked,
    output int                            o_fail_count,
    output logic [pnet_pkg::SLOTS-1:0]    o_fired_seen
);
    import pnet_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // shadow of the register file and of the marking
    logic [DATA_W-1:0]    in_lo, in_hi, out_lo, out_hi;
    logic [DATA_W-1:0]    ev_types, src_roles, tgt_roles;
    logic [CTRL_W-1:0]    net_ctrl;
    logic [MASK_BITS-1:0] marks;

    t_result_word predicted_q[$];

    // Walk the transitions in slot order; each firing updates the marking
    // that the following slots see.
    function automatic t_result_word fire_event(input t_event_word w);
        t_result_word         r;
        logic [MASK_BITS-1:0] im, om;
        logic [CODE_W-1:0]    tt, rs, rt;
        r = '0;
        if (w.kind) begin
            marks = net_ctrl[MASK_BITS-1:0];
        end else if (net_ctrl[CTRL_LOADED] && w.event_type != '0) begin
            for (int t = 0; t < SLOTS; t++) begin
                im = (t < 4) ? in_lo[16*(t%4) +: 16] : in_hi[16*(t%4) +: 16];
                om = (t < 4) ? out_lo[16*(t%4) +: 16] : out_hi[16*(t%4) +: 16];
                tt = ev_types[8*t +: 8];
                rs = src_roles[8*t +: 8];
                rt = tgt_roles[8*t +: 8];
                if (tt != '0 && tt == w.event_type
                    && (rs == '0 || w.source_role == '0 || rs == w.source_role)
                    && (rt == '0 || w.target_role == '0 || rt == w.target_role)
                    && (marks & im) == im) begin
                    marks = (marks & ~im) | om;
                    r.fired_transitions[t] = 1'b1;
                end
            end
        end
        r.marking      = marks;
        r.goal_reached = net_ctrl[CTRL_LOADED] && net_ctrl[CTRL_GOAL_EN]
                         && marks[net_ctrl[CTRL_GOAL_LSB +: GOAL_W]];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result_word due;
        t_reg_idx     widx;
        if (!i_rst_n) begin
            in_lo = '0; in_hi = '0; out_lo = '0; out_hi = '0;
            ev_types = '0; src_roles = '0; tgt_roles = '0;
            net_ctrl = '0;
            marks = '0;
            predicted_q.delete();
            o_checked = 0;
            o_fail_count = 0;
            o_fired_seen = '0;
        end else begin
            if (i_res_valid && !i_res_stall) begin
                o_checked++;
                if (predicted_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT)
                        $display("unexpected result word %0d: got %h", o_checked, i_res_word);
                end else begin
                    due = predicted_q.pop_front();
                    o_fired_seen |= i_res_word.fired_transitions;
                    if (i_res_word.marking !== due.marking
                        || i_res_word.fired_transitions !== due.fired_transitions
                        || i_res_word.goal_reached !== due.goal_reached) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT)
                            $display("result word %0d: marking exp %h got %h, fired exp %b got %b, goal exp %b got %b",
                                     o_checked, due.marking, i_res_word.marking,
                                     due.fired_transitions, i_res_word.fired_transitions,
                                     due.goal_reached, i_res_word.goal_reached);
                    end
                end
            end
            if (i_evt_valid && !i_evt_stall)
                predicted_q.push_back(fire_event(i_evt_word));
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                widx = t_reg_idx'(i_paddr[ADDR_W-1:3]);
                case (widx)
                    REG_INPUTS_LO:  in_lo = i_pwdata;
                    REG_INPUTS_HI:  in_hi = i_pwdata;
                    REG_OUTPUTS_LO: out_lo = i_pwdata;
                    REG_OUTPUTS_HI: out_hi = i_pwdata;
                    REG_EVT_TYPES:  ev_types = i_pwdata;
                    REG_SRC_ROLES:  src_roles = i_pwdata;
                    REG_TGT_ROLES:  tgt_roles = i_pwdata;
                    REG_NET_CTRL:   net_ctrl = i_pwdata[CTRL_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = predicted_q.size();
    end

endmodule

// ===== test/tb_petri_net_event_tracker.sv =====
`timescale 1ns / 100ps
// Top of the Petri net event tracker regression: clock, reset, stimulus and verdict.
// Depends on pnet_pkg, petri_net_event_tracker and pnet_firing_check.
module tb_petri_net_event_tracker;
    import pnet_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RESET_CYCLES  = 11;
    localparam int HOLD_CYCLES   = 300;
    localparam int NET_PHASES    = 14;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;

    // Every block input starts at a known value.
    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 i_valid = 1'b0;
    t_event_word          i_event = '0;
    logic                 i_stall = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_W-1:0]    paddr   = '0;
    logic [DATA_W-1:0]    pwdata  = '0;

    logic                 o_stall, o_valid, pready;
    t_result_word         o_result;
    logic [DATA_W-1:0]    prdata;

    int                   pending, checked, fail_count;
    logic [SLOTS-1:0]     fired_seen;

    // idling knobs, in percent of cycles
    int sender_idle_pct = 0;
    int stall_pct       = 0;

    // long receiver hold-off: the stimulus asks, the receiver process counts
    int hold_asks   = 0;
    int hold_served = 0;
    int hold_left   = 0;

    int words_sent     = 0;
    int settings_used  = 0;
    int cycles         = 0;

    always #1 clk = ~clk;

    petri_net_event_tracker dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_event  (i_event),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pnet_firing_check firing_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_evt_valid  (i_valid),
        .i_evt_stall  (o_stall),
        .i_evt_word   (i_event),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_res_word   (o_result),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_fail_count (fail_count),
        .o_fired_seen (fired_seen)
    );

    // Hard stop in case the block hangs.
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
            $display("petri_net_event_tracker regression: fail");
            $finish;
        end
    end

    // Result side: random stall, or hold off for a long stretch when asked.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_asks != hold_served) begin
            i_stall     <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_served <= hold_asks;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic t_event_word make_word(input logic kind, input logic [7:0] etype,
                                              input logic [7:0] src, input logic [7:0] tgt);
        t_event_word w;
        w.kind        = kind;
        w.event_type  = etype;
        w.source_role = src;
        w.target_role = tgt;
        return w;
    endfunction

    function automatic t_event_word random_word();
        return make_word(1'($urandom_range(1)), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // Mostly events that the nets know about, with small role codes so that
    // role matches and mismatches both happen; a few restarts to refill the
    // marking, some all-ones hits and some fully random noise.
    function automatic t_event_word pick_event();
        int roll;
        roll = $urandom_range(99);
        if (roll < 7)
            return make_word(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
        if (roll < 17)
            return random_word();
        if (roll < 22)
            return make_word(1'b0, 8'hFF, 8'($urandom_range(1) ? 8'hFF : 8'h00),
                             8'($urandom_range(1) ? 8'hFF : 8'($urandom)));
        return make_word(1'b0, 8'($urandom_range(1, 4)), 8'($urandom_range(0, 3)),
                         8'($urandom_range(0, 3)));
    endfunction

    function automatic logic [DATA_W-1:0] ctrl_word(input logic loaded, input logic goal_en,
                                                    input logic [GOAL_W-1:0] goal,
                                                    input logic [MASK_BITS-1:0] init);
        return DATA_W'({loaded, goal_en, goal, init});
    endfunction

    // APB write: setup cycle, access cycle, then drop the select.
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one word, possibly after a random gap; return at the falling edge
    // after it was taken, with valid still high.
    task automatic send_word(input t_event_word w);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            i_event <= random_word();
            @(negedge clk);
        end
        i_valid <= 1'b1;
        i_event <= w;
        do @(posedge clk); while (o_stall);
        @(negedge clk);
        words_sent++;
    endtask

    // Drop valid, wait for every predicted result, then let the pipe settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 80; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 80; end
            default: begin sender_idle_pct = 26; stall_pct = 26; end
        endcase
    endtask

    task automatic fill_net(input logic [DATA_W-1:0] fill);
        for (t_reg_idx r = REG_INPUTS_LO; r != REG_NET_CTRL; r = r.next())
            write_reg(r, fill);
        write_reg(REG_NET_CTRL, DATA_W'(fill[CTRL_W-1:0]));
        settings_used++;
    endtask

    task automatic write_net(input logic [SLOTS-1:0][MASK_BITS-1:0] ins,
                             input logic [SLOTS-1:0][MASK_BITS-1:0] outs,
                             input logic [SLOTS-1:0][CODE_W-1:0] types,
                             input logic [SLOTS-1:0][CODE_W-1:0] srcs,
                             input logic [SLOTS-1:0][CODE_W-1:0] tgts,
                             input logic [DATA_W-1:0] ctrl);
        write_reg(REG_INPUTS_LO, ins[3:0]);
        write_reg(REG_INPUTS_HI, ins[7:4]);
        write_reg(REG_OUTPUTS_LO, outs[3:0]);
        write_reg(REG_OUTPUTS_HI, outs[7:4]);
        write_reg(REG_EVT_TYPES, types);
        write_reg(REG_SRC_ROLES, srcs);
        write_reg(REG_TGT_ROLES, tgts);
        write_reg(REG_NET_CTRL, ctrl);
        settings_used++;
    endtask

    // Random net: sparse masks so tokens move, small type and role codes so
    // that events match, occasionally an unused slot or an odd type code.
    task automatic load_random_net();
        logic [SLOTS-1:0][MASK_BITS-1:0] ins, outs;
        logic [SLOTS-1:0][CODE_W-1:0]    types, srcs, tgts;
        logic [MASK_BITS-1:0]            init;
        for (int t = 0; t < SLOTS; t++) begin
            ins[t]  = 16'h1 << $urandom_range(15);
            outs[t] = 16'h1 << $urandom_range(15);
            if ($urandom_range(1)) ins[t]  |= 16'h1 << $urandom_range(15);
            if ($urandom_range(1)) outs[t] |= 16'h1 << $urandom_range(15);
            if ($urandom_range(9) == 0) ins[t] = '0;
            types[t] = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(1, 4));
            if ($urandom_range(15) == 0) types[t] = 8'($urandom);
            srcs[t] = $urandom_range(1) ? 8'h00 : 8'($urandom_range(1, 3));
            tgts[t] = $urandom_range(1) ? 8'h00 : 8'($urandom_range(1, 3));
        end
        init = 16'($urandom) & 16'($urandom) | (16'h1 << $urandom_range(15));
        write_net(ins, outs, types, srcs, tgts,
                  ctrl_word($urandom_range(7) != 0, $urandom_range(7) != 0,
                            4'($urandom_range(15)), init));
    endtask

    // Hand-built net for the directed part: a two-slot chain on type 1,
    // role-gated slots on types 2 and 3 feeding the goal place, an unused
    // slot, an always-enabled slot on type 0xFF and a slot waiting on a
    // place that is never marked.
    task automatic load_demo_net();
        logic [SLOTS-1:0][MASK_BITS-1:0] ins, outs;
        logic [SLOTS-1:0][CODE_W-1:0]    types, srcs, tgts;
        ins = '0; outs = '0; types = '0; srcs = '0; tgts = '0;
        ins[0] = 16'h0001; outs[0] = 16'h0002; types[0] = 8'd1;
        ins[1] = 16'h0002; outs[1] = 16'h0004; types[1] = 8'd1;
        ins[2] = 16'h0004; outs[2] = 16'h0008; types[2] = 8'd2; srcs[2] = 8'd5;
        ins[3] = 16'h0008; outs[3] = 16'h8000; types[3] = 8'd3; tgts[3] = 8'd7;
        ins[4] = 16'h0000; outs[4] = 16'hFFFF; types[4] = 8'd0;
        ins[5] = 16'h0000; outs[5] = 16'h0010; types[5] = 8'hFF;
        srcs[5] = 8'hFF;   tgts[5] = 8'hFF;
        ins[6] = 16'h8010; outs[6] = 16'h0001; types[6] = 8'd4;
        ins[7] = 16'h0200; outs[7] = 16'h0000; types[7] = 8'd2;
        write_net(ins, outs, types, srcs, tgts, ctrl_word(1'b1, 1'b1, 4'hF, 16'h0001));
    endtask

    initial begin
        // Hold reset, then release at a falling edge.
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset net first: nothing loaded, restart loads zero.
        send_word(make_word(1'b0, 8'd1, 8'd0, 8'd0));
        send_word(make_word(1'b1, 8'hFF, 8'hFF, 8'hFF));
        drain();
        load_demo_net();
        send_word(make_word(1'b0, 8'd1, 8'd0, 8'd0));        // empty marking, no firing
        send_word(make_word(1'b1, 8'd0, 8'd0, 8'd0));        // restart
        send_word(make_word(1'b0, 8'd1, 8'd3, 8'd9));        // chain of two in one word
        send_word(make_word(1'b0, 8'd2, 8'd6, 8'd0));        // source role mismatch
        send_word(make_word(1'b0, 8'd2, 8'd0, 8'd0));        // absent source role
        send_word(make_word(1'b0, 8'd3, 8'd1, 8'd6));        // target role mismatch
        send_word(make_word(1'b0, 8'd3, 8'd1, 8'd7));        // reaches the goal place
        send_word(make_word(1'b0, 8'd0, 8'd5, 8'd7));        // empty event type
        send_word(make_word(1'b0, 8'hFF, 8'hFF, 8'hFF));     // extreme codes, all match
        send_word(make_word(1'b0, 8'd4, 8'd0, 8'd0));        // join of two places
        send_word(make_word(1'b0, 8'hFF, 8'h01, 8'h00));     // source mismatch on 0xFF
        send_word(make_word(1'b0, 8'hFF, 8'h00, 8'hFF));
        send_word(make_word(1'b0, 8'h80, 8'h80, 8'h80));     // type known to no slot
        send_word(make_word(1'b1, 8'h55, 8'hAA, 8'h55));     // restart ignores fields
        send_word(make_word(1'b0, 8'd1, 8'hFF, 8'hFF));      // any-role slots
        drain();
        // Net not loaded: events change nothing, restart still loads.
        write_reg(REG_NET_CTRL, ctrl_word(1'b0, 1'b0, 4'h2, 16'h0001));
        settings_used++;
        send_word(make_word(1'b0, 8'd2, 8'd5, 8'd0));
        send_word(make_word(1'b1, 8'd0, 8'd0, 8'd0));
        send_word(make_word(1'b0, 8'd1, 8'd0, 8'd0));
        drain();
        // Loaded with goal disabled, then goal enabled on the same place.
        write_reg(REG_NET_CTRL, ctrl_word(1'b1, 1'b0, 4'h2, 16'h0001));
        settings_used++;
        send_word(make_word(1'b0, 8'd1, 8'd0, 8'd0));
        drain();
        write_reg(REG_NET_CTRL, ctrl_word(1'b1, 1'b1, 4'h2, 16'h0001));
        settings_used++;
        send_word(make_word(1'b0, 8'd0, 8'd0, 8'd0));

        // Random part: all-ones net, all-zeros net, then random nets, each
        // phase under the idling pattern that its number modulo four selects.
        for (int p = 0; p < NET_PHASES; p++) begin
            drain();
            if (p == 0)
                fill_net('1);
            else if (p == 1)
                fill_net('0);
            else
                load_random_net();
            set_idling(p % 4);
            // Phase without idling: hold off the result side for a long
            // stretch while the sender keeps pushing, so the input backs up.
            if (p == 4)
                hold_asks++;
            for (int i = 0; i < ((p == 0) ? 60 : (p == 1) ? 40 : 130); i++)
                send_word(pick_event());
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("covered %0d event words over %0d net settings, %0d results compared",
                 words_sent, settings_used, checked);
        $display("transition slots seen firing %b, one result hold-off of %0d cycles",
                 fired_seen, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("petri_net_event_tracker regression: pass");
        end else begin
            $display("%0d failing results", fail_count);
            $display("petri_net_event_tracker regression: fail");
        end
        $finish;
    end

endmodule
